### rtl/core/hht_pkg.sv
// Package of the hopscotch hash table: sizes, codes, memory row layout and
// the command and status structs between controller and datapath. No dependencies.
package hht_pkg;

  // Table size; must be a power of two.
  localparam int NUM_BUCKETS = 1024;
  localparam int IDX_W       = $clog2(NUM_BUCKETS);
  localparam int CNT_W       = IDX_W + 1;

  // Fixed field widths of the request and response channels.
  localparam int REQ_W  = 2;
  localparam int KEY_W  = 32;
  localparam int HASH_W = 32;
  localparam int VAL_W  = 32;
  localparam int BI_W   = 10;
  localparam int USED_W = 11;
  localparam int NH_W   = 11;
  localparam int ST_W   = 2;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [NH_W-1:0] NH_RESET = NH_W'(8);

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 2'd0,
    ST_LARGER_TABLE = 2'd1,
    ST_LARGER_NH    = 2'd2,
    ST_ZERO_HASH    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BASE_ZERO,
    BASE_BEGIN,
    BASE_END,
    BASE_SPAN,
    BASE_BI
  } base_e;

  typedef enum logic [1:0] {
    WA_CUR,
    WA_HOLE,
    WA_MV
  } waddr_e;

  typedef enum logic [1:0] {
    WD_ZERO,
    WD_MOVE,
    WD_NEW
  } wdata_e;

  typedef enum logic [1:0] {
    RB_ZERO,
    RB_HOLE,
    RB_BI
  } rbsel_e;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } row_t;

  typedef struct packed {
    logic    load;
    logic    set_base;
    base_e   base_sel;
    logic    inc;
    logic    rd;
    logic    take_hole;
    logic    take_mv;
    logic    track;
    logic    wr;
    waddr_e  wa_sel;
    wdata_e  wd_sel;
    logic    hole_from_mv;
    logic    occ_inc;
    logic    occ_dec;
    logic    occ_clr;
    logic    res_set;
    status_e res_st;
    rbsel_e  res_rb;
    logic    res_new;
  } cmd_t;

  typedef struct packed {
    req_e req_type;
    logic zero_hash;
    logic bi_ok;
    logic hit_empty;
    logic hit_match;
    logic movable;
    logic all_same;
    logic last_nh;
    logic last_out;
    logic last_span;
    logic last_all;
    logic in_nh;
    logic span_zero;
    logic nh_full;
  } stat_t;

endpackage

### rtl/core/hht_req_if.sv
// Request channel of the hopscotch hash table: valid, ready and request fields.
// Depends on hht_pkg for the field widths.
interface hht_req_if;
  logic                          valid;
  logic                          ready;
  logic [hht_pkg::REQ_W-1:0]     req_type;
  logic [hht_pkg::KEY_W-1:0]     key;
  logic [hht_pkg::HASH_W-1:0]    key_hash;
  logic [hht_pkg::VAL_W-1:0]     value;
  logic [hht_pkg::BI_W-1:0]      bucket_index;

  modport source (output valid, req_type, key, key_hash, value, bucket_index, input ready);
  modport sink (input valid, req_type, key, key_hash, value, bucket_index, output ready);
endinterface

### rtl/core/hht_rsp_if.sv
// Response channel of the hopscotch hash table: valid, ready and result fields.
// Depends on hht_pkg for the field widths.
interface hht_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [hht_pkg::BI_W-1:0]   result_bucket;
  logic                       is_new;
  logic [hht_pkg::ST_W-1:0]   status;
  logic [hht_pkg::USED_W-1:0] used_count;

  modport source (output valid, result_bucket, is_new, status, used_count, input ready);
  modport sink (input valid, result_bucket, is_new, status, used_count, output ready);
endinterface

### rtl/core/hht_ctrl.sv
// Controller of the hopscotch hash table: sequences scans, hops, writes and results.
// Depends on hht_pkg for the command and status structs.
module hht_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  input  hht_pkg::stat_t stat_i,
  output hht_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_NB_RD, S_NB_CHK, S_OUT_RD, S_OUT_CHK, S_HOP,
    S_MV_RD, S_MV_CHK, S_MV_W1, S_MV_W2, S_FINAL, S_RM_RD, S_RM_CHK, S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic                 rsp_valid_q, rsp_valid_d;
  logic                 from_req_q, from_req_d;
  hht_pkg::status_e     res_st_q, res_st_d;
  hht_pkg::rbsel_e      res_rb_q, res_rb_d;
  logic                 res_new_q, res_new_d;
  logic                 out_free;

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d    = state_q;
    from_req_d = from_req_q;
    res_st_d   = res_st_q;
    res_rb_d   = res_rb_q;
    res_new_d  = res_new_q;
    cmd_o      = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.wr     = 1'b1;
        cmd_o.wa_sel = hht_pkg::WA_CUR;
        cmd_o.wd_sel = hht_pkg::WD_ZERO;
        cmd_o.inc    = 1'b1;
        if (stat_i.last_all) begin
          state_d = from_req_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          res_new_d  = 1'b0;
          res_st_d   = hht_pkg::ST_OK;
          res_rb_d   = hht_pkg::RB_ZERO;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.req_type)
          hht_pkg::REQ_INSERT: begin
            if (stat_i.zero_hash) begin
              res_st_d = hht_pkg::ST_ZERO_HASH;
              state_d  = S_DONE;
            end else begin
              cmd_o.set_base = 1'b1;
              cmd_o.base_sel = hht_pkg::BASE_BEGIN;
              state_d        = S_NB_RD;
            end
          end
          hht_pkg::REQ_REMOVE: begin
            res_rb_d = hht_pkg::RB_BI;
            if (stat_i.bi_ok) begin
              cmd_o.set_base = 1'b1;
              cmd_o.base_sel = hht_pkg::BASE_BI;
              state_d        = S_RM_RD;
            end else begin
              state_d = S_DONE;
            end
          end
          hht_pkg::REQ_CLEAR: begin
            cmd_o.set_base = 1'b1;
            cmd_o.base_sel = hht_pkg::BASE_ZERO;
            cmd_o.occ_clr  = 1'b1;
            from_req_d     = 1'b1;
            state_d        = S_CLEAR;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_NB_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_NB_CHK;
      end
      S_NB_CHK: begin
        if (stat_i.hit_empty || stat_i.hit_match) begin
          cmd_o.take_hole = 1'b1;
          state_d         = S_FINAL;
        end else if (stat_i.last_nh) begin
          if (stat_i.nh_full) begin
            res_st_d = hht_pkg::ST_LARGER_TABLE;
            state_d  = S_DONE;
          end else begin
            cmd_o.set_base = 1'b1;
            cmd_o.base_sel = hht_pkg::BASE_END;
            state_d        = S_OUT_RD;
          end
        end else begin
          cmd_o.inc = 1'b1;
          state_d   = S_NB_RD;
        end
      end
      S_OUT_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_OUT_CHK;
      end
      S_OUT_CHK: begin
        if (stat_i.hit_empty) begin
          cmd_o.take_hole = 1'b1;
          state_d         = S_HOP;
        end else if (stat_i.last_out) begin
          res_st_d = hht_pkg::ST_LARGER_TABLE;
          state_d  = S_DONE;
        end else begin
          cmd_o.inc = 1'b1;
          state_d   = S_OUT_RD;
        end
      end
      S_HOP: begin
        if (stat_i.in_nh) begin
          state_d = S_FINAL;
        end else if (stat_i.span_zero) begin
          res_st_d = hht_pkg::ST_LARGER_NH;
          state_d  = S_DONE;
        end else begin
          cmd_o.set_base = 1'b1;
          cmd_o.base_sel = hht_pkg::BASE_SPAN;
          state_d        = S_MV_RD;
        end
      end
      S_MV_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MV_CHK;
      end
      S_MV_CHK: begin
        cmd_o.track = 1'b1;
        if (stat_i.movable) begin
          cmd_o.take_mv = 1'b1;
          state_d       = S_MV_W1;
        end else if (stat_i.last_span) begin
          res_st_d = stat_i.all_same ? hht_pkg::ST_LARGER_NH : hht_pkg::ST_LARGER_TABLE;
          state_d  = S_DONE;
        end else begin
          cmd_o.inc = 1'b1;
          state_d   = S_MV_RD;
        end
      end
      S_MV_W1: begin
        cmd_o.wr     = 1'b1;
        cmd_o.wa_sel = hht_pkg::WA_HOLE;
        cmd_o.wd_sel = hht_pkg::WD_MOVE;
        state_d      = S_MV_W2;
      end
      S_MV_W2: begin
        cmd_o.wr           = 1'b1;
        cmd_o.wa_sel       = hht_pkg::WA_MV;
        cmd_o.wd_sel       = hht_pkg::WD_ZERO;
        cmd_o.hole_from_mv = 1'b1;
        state_d            = S_HOP;
      end
      S_FINAL: begin
        cmd_o.wr      = 1'b1;
        cmd_o.wa_sel  = hht_pkg::WA_HOLE;
        cmd_o.wd_sel  = hht_pkg::WD_NEW;
        cmd_o.occ_inc = 1'b1;
        res_new_d     = 1'b1;
        res_rb_d      = hht_pkg::RB_HOLE;
        state_d       = S_DONE;
      end
      S_RM_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_RM_CHK;
      end
      S_RM_CHK: begin
        if (!stat_i.hit_empty) begin
          cmd_o.wr      = 1'b1;
          cmd_o.wa_sel  = hht_pkg::WA_CUR;
          cmd_o.wd_sel  = hht_pkg::WD_ZERO;
          cmd_o.occ_dec = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.res_st  = res_st_q;
        cmd_o.res_rb  = res_rb_q;
        cmd_o.res_new = res_new_q;
        if (out_free) begin
          cmd_o.res_set = 1'b1;
          from_req_d    = 1'b0;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.res_set) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rsp_valid_q <= 1'b0;
      from_req_q  <= 1'b0;
      res_st_q    <= hht_pkg::ST_OK;
      res_rb_q    <= hht_pkg::RB_ZERO;
      res_new_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      from_req_q  <= from_req_d;
      res_st_q    <= res_st_d;
      res_rb_q    <= res_rb_d;
      res_new_q   <= res_new_d;
    end
  end

endmodule

### rtl/core/hht_dpath.sv
// Datapath of the hopscotch hash table: bucket memory, scan counter, hole tracking,
// configuration register and result registers. Depends on hht_pkg.
module hht_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hht_pkg::cmd_t                 cmd_i,
  output hht_pkg::stat_t                stat_o,
  input  logic [hht_pkg::REQ_W-1:0]     req_type_i,
  input  logic [hht_pkg::KEY_W-1:0]     key_i,
  input  logic [hht_pkg::HASH_W-1:0]    key_hash_i,
  input  logic [hht_pkg::VAL_W-1:0]     value_i,
  input  logic [hht_pkg::BI_W-1:0]      bucket_index_i,
  output logic [hht_pkg::BI_W-1:0]      result_bucket_o,
  output logic                          is_new_o,
  output logic [hht_pkg::ST_W-1:0]      status_o,
  output logic [hht_pkg::USED_W-1:0]    used_count_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hht_pkg::APB_AW-1:0]    paddr,
  input  logic [hht_pkg::APB_DW-1:0]    pwdata,
  output logic [hht_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int IW = hht_pkg::IDX_W;
  localparam int CW = hht_pkg::CNT_W;

  hht_pkg::row_t               store_q [hht_pkg::NUM_BUCKETS];
  hht_pkg::row_t               rd_q, mvrow_q, wdata;
  logic [IW-1:0]               waddr, cur, base_d;
  logic [IW-1:0]               base_q, hole_q, mv_q;
  logic [CW-1:0]               cnt_q, nhe_q, nhe_d, span;
  logic [CW-1:0]               occ_q;
  logic [hht_pkg::NH_W-1:0]    nh_q;
  logic [hht_pkg::HASH_W-1:0]  kh_q, sample_q;
  logic [hht_pkg::KEY_W-1:0]   key_q;
  logic [hht_pkg::VAL_W-1:0]   val_q;
  logic [hht_pkg::BI_W-1:0]    bi_q;
  hht_pkg::req_e               req_q;
  logic                        new_q, same_q;
  logic [hht_pkg::HASH_W-1:0]  h;
  logic [IW-1:0]               home_dist, begin_dist;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[hht_pkg::APB_AW-1];
  assign prdata = paddr[hht_pkg::APB_AW-1] ? '0 : hht_pkg::APB_DW'(nh_q);

  always_comb begin
    if (nh_q == '0) begin
      nhe_d = CW'(1);
    end else if (32'(nh_q) > hht_pkg::NUM_BUCKETS) begin
      nhe_d = CW'(hht_pkg::NUM_BUCKETS);
    end else begin
      nhe_d = CW'(nh_q);
    end
  end

  assign span       = nhe_q - CW'(1);
  assign cur        = base_q + cnt_q[IW-1:0];
  assign h          = rd_q.hash;
  assign home_dist  = hole_q - h[IW-1:0];
  assign begin_dist = hole_q - kh_q[IW-1:0];

  always_comb begin
    case (cmd_i.base_sel)
      hht_pkg::BASE_BEGIN: base_d = kh_q[IW-1:0];
      hht_pkg::BASE_END:   base_d = kh_q[IW-1:0] + nhe_q[IW-1:0];
      hht_pkg::BASE_SPAN:  base_d = hole_q - span[IW-1:0];
      hht_pkg::BASE_BI:    base_d = IW'(bi_q);
      default:             base_d = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wa_sel)
      hht_pkg::WA_HOLE: waddr = hole_q;
      hht_pkg::WA_MV:   waddr = mv_q;
      default:          waddr = cur;
    endcase
    case (cmd_i.wd_sel)
      hht_pkg::WD_MOVE: wdata = mvrow_q;
      hht_pkg::WD_NEW:  wdata = '{hash: kh_q, key: key_q, value: val_q};
      default:          wdata = '0;
    endcase
  end

  always_comb begin
    stat_o.req_type  = req_q;
    stat_o.zero_hash = (kh_q == '0);
    stat_o.bi_ok     = (32'(bi_q) < hht_pkg::NUM_BUCKETS);
    stat_o.hit_empty = (h == '0);
    stat_o.hit_match = (h == kh_q) && (rd_q.key == key_q);
    stat_o.movable   = (h != '0) && ({1'b0, home_dist} < nhe_q);
    stat_o.all_same  = (cnt_q == '0) || (same_q && (h == sample_q));
    stat_o.last_nh   = (cnt_q + CW'(1) == nhe_q);
    stat_o.last_out  = (cnt_q + CW'(1) == CW'(hht_pkg::NUM_BUCKETS) - nhe_q);
    stat_o.last_span = (cnt_q + CW'(1) == span);
    stat_o.last_all  = (cnt_q[IW-1:0] == IW'(hht_pkg::NUM_BUCKETS - 1));
    stat_o.in_nh     = ({1'b0, begin_dist} < nhe_q);
    stat_o.span_zero = (span == '0);
    stat_o.nh_full   = (nhe_q == CW'(hht_pkg::NUM_BUCKETS));
  end

  // Bucket memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      store_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rd_q <= store_q[cur];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nh_q   <= hht_pkg::NH_RESET;
      cnt_q  <= '0;
      base_q <= '0;
      occ_q  <= '0;
    end else begin
      if (cfg_wr) begin
        nh_q <= pwdata[hht_pkg::NH_W-1:0];
      end
      if (cmd_i.set_base) begin
        base_q <= base_d;
        cnt_q  <= '0;
      end else if (cmd_i.inc) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.occ_clr) begin
        occ_q <= '0;
      end else if (cmd_i.occ_inc && new_q) begin
        occ_q <= occ_q + CW'(1);
      end else if (cmd_i.occ_dec && occ_q != '0) begin
        occ_q <= occ_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= hht_pkg::req_e'(req_type_i);
      kh_q  <= key_hash_i;
      key_q <= key_i;
      val_q <= value_i;
      bi_q  <= bucket_index_i;
      nhe_q <= nhe_d;
    end
    if (cmd_i.take_hole) begin
      hole_q <= cur;
      new_q  <= (h == '0);
    end else if (cmd_i.hole_from_mv) begin
      hole_q <= mv_q;
    end
    if (cmd_i.take_mv) begin
      mv_q    <= cur;
      mvrow_q <= rd_q;
    end
    if (cmd_i.track) begin
      if (cnt_q == '0) begin
        sample_q <= h;
        same_q   <= 1'b1;
      end else if (h != sample_q) begin
        same_q <= 1'b0;
      end
    end
    if (cmd_i.res_set) begin
      case (cmd_i.res_rb)
        hht_pkg::RB_HOLE: result_bucket_o <= hht_pkg::BI_W'(hole_q);
        hht_pkg::RB_BI:   result_bucket_o <= bi_q;
        default:          result_bucket_o <= '0;
      endcase
      is_new_o     <= cmd_i.res_new && new_q;
      status_o     <= cmd_i.res_st;
      used_count_o <= hht_pkg::USED_W'(occ_q);
    end
  end

endmodule

### rtl/core/hopscotch_hash_table.sv
// Hopscotch hash table of hht_pkg::NUM_BUCKETS buckets with insert-or-assign, remove
// and clear requests; one response per request. The block takes one request at a time.
// Every bucket visit has a read state for the bucket memory and a check state for the
// registered word. An insert scans its neighborhood from the home bucket for an empty
// or matching bucket. Failing that, it searches the buckets beyond for an empty one.
// Each hop checks buckets in turn, the source included, then writes the moved entry
// into the hole, clears the source and checks again. A remove reads the given bucket
// and clears it if occupied; a no-operation or zero-hash insert goes straight to the
// response. A clear sweeps the table at one bucket per cycle, and the same clearing
// pass runs right after reset, during which no request is accepted while configuration
// writes work. The response sits in an output register, so a new request is taken while
// the last response still waits. Depends on hht_pkg, hht_req_if, hht_rsp_if, hht_ctrl,
// hht_dpath.
module hopscotch_hash_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hht_req_if.sink                     req_i,
  hht_rsp_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hht_pkg::APB_AW-1:0]  paddr,
  input  logic [hht_pkg::APB_DW-1:0]  pwdata,
  output logic [hht_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  // The controller steps through the neighborhood scan, the search for an empty bucket,
  // the hop loop and the final write, as well as removes and clears; the datapath holds the table storage.
  hht_pkg::cmd_t  cmd;
  hht_pkg::stat_t stat;

  hht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  hht_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .req_type_i      (req_i.req_type),
    .key_i           (req_i.key),
    .key_hash_i      (req_i.key_hash),
    .value_i         (req_i.value),
    .bucket_index_i  (req_i.bucket_index),
    .result_bucket_o (rsp_o.result_bucket),
    .is_new_o        (rsp_o.is_new),
    .status_o        (rsp_o.status),
    .used_count_o    (rsp_o.used_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

endmodule

### rtl/core/hht_checker.sv
// Port-level checks for the hopscotch hash table, bound to the top level.
// Depends on hht_pkg and hopscotch_hash_table.
module hht_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [hht_pkg::BI_W-1:0]    result_bucket_i,
  input logic                        is_new_i,
  input logic [hht_pkg::ST_W-1:0]    status_i,
  input logic [hht_pkg::USED_W-1:0]  used_count_i
);

  // A pending response is not withdrawn.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // The block works on one request at a time.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // A failed insert reports neither a bucket nor a new entry.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != hht_pkg::ST_OK |-> result_bucket_i == '0 && !is_new_i)
    else $error("failed insert reports a bucket");

  // The occupancy never exceeds the table.
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> 32'(used_count_i) <= hht_pkg::NUM_BUCKETS)
    else $error("used count beyond table size");

endmodule

bind hopscotch_hash_table hht_checker u_hht_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .result_bucket_i (rsp_o.result_bucket),
  .is_new_i        (rsp_o.is_new),
  .status_i        (rsp_o.status),
  .used_count_i    (rsp_o.used_count)
);
